>>> src/assert_macros.svh
// Assertion macros for the checker file of the matrix inverse block.
// Each use expects clk and arst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define MI3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Property checked on every rising edge, reset included.
`define MI3_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mi3_pkg.sv
// Package of the 3x3 matrix inverse: coefficient width and the word types
// of the matrix and inverse channels. No dependencies.
`default_nettype none

package mi3_pkg;

	// Coefficient width of every matrix and inverse entry (signed fixed point).
	localparam int COEF_W = 32;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic  mode_3x3;
		coef_t r0c0;
		coef_t r0c1;
		coef_t r0c2;
		coef_t r1c0;
		coef_t r1c1;
		coef_t r1c2;
		coef_t r2c0;
		coef_t r2c1;
		coef_t r2c2;
	} mat_word_t;

	typedef struct packed {
		coef_t inv_r0c0;
		coef_t inv_r0c1;
		coef_t inv_r0c2;
		coef_t inv_r1c0;
		coef_t inv_r1c1;
		coef_t inv_r1c2;
		coef_t inv_r2c0;
		coef_t inv_r2c1;
		coef_t inv_r2c2;
		logic  singular;
		logic  saturated;
	} inv_word_t;

endpackage

`default_nettype wire

>>> src/matrix_inverse_3x3.sv
// Top level of the 3x3 matrix inverse: cofactor and determinant pipeline,
// nine divider lanes and an output skid register. Uses mi3_pkg, mi3_div_lane.
//
// Usage
//   One matrix word enters on the mat channel (mat_valid, mat_stall, mat) and
//   one inverse word leaves on the inv channel (inv_valid, inv_stall, inv).
//   A word moves at a rising edge where valid is high and stall is low.
//   mode_3x3 low inverts the upper-left 2x2 block only; the other five
//   inverse entries then read zero. A zero determinant gives an all-zero
//   word with singular set and saturated clear.
//   Throughput: one matrix per cycle while mat_stall is low.
//   Pipeline: six stages of products, cofactors, determinant and magnitudes,
//   then one divider stage per quotient bit (COEF_W + 1) and one rounding
//   stage. Reset clears every valid bit, the skid flag included; no word
//   comes out until one has gone in. When the receiver stalls, the pending
//   inverse drops into the skid register and the pipeline still advances at
//   that edge; mat_stall then rises and the whole pipeline holds until the
//   skid word has been taken.
`default_nettype none

module matrix_inverse_3x3 #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               mat_valid,
	output logic                    mat_stall,
	input  wire mi3_pkg::mat_word_t mat,
	output logic                    inv_valid,
	input  wire logic               inv_stall,
	output mi3_pkg::inv_word_t      inv
);

	localparam int W     = mi3_pkg::COEF_W;
	localparam int PW    = 2 * W;           // entry product
	localparam int CFW   = 2 * W + 1;       // cofactor
	localparam int PLW   = 2 * W + 2;       // entry times low cofactor half
	localparam int TW    = 3 * W + 2;       // one determinant term
	localparam int DTW   = 3 * W + 4;       // determinant
	localparam int NMW   = 2 * W + 2 * FRAC_BITS;
	localparam int LL    = W + 2;           // divider lane depth

	// cofactor i = m[IA]*m[IB] - m[IC]*m[ID]
	localparam int IA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int IB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int IC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int ID [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	// advance the whole pipeline unless the skid register is occupied
	logic adv;
	logic skid_v_q;
	mi3_pkg::inv_word_t skid_q;
	mi3_pkg::inv_word_t pipe_word;

	assign adv = !skid_v_q;

	mi3_pkg::coef_t m_in [9];
	always_comb begin
		m_in[0] = mat.r0c0;
		m_in[1] = mat.r0c1;
		m_in[2] = mat.r0c2;
		m_in[3] = mat.r1c0;
		m_in[4] = mat.r1c1;
		m_in[5] = mat.r1c2;
		m_in[6] = mat.r2c0;
		m_in[7] = mat.r2c1;
		m_in[8] = mat.r2c2;
	end

	// valid bits travelling with the data
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [LL-1:0] tail_v_q;
	logic [LL-1:0] tail_z_q;

	// stage payloads
	logic                  mode_s1, mode_s2, mode_s3, mode_s4;
	mi3_pkg::coef_t        m_s1   [9];
	logic signed [PW-1:0]  pa_s1  [9];
	logic signed [PW-1:0]  pb_s1  [9];
	logic signed [CFW-1:0] cofo_s2 [9];
	logic signed [CFW-1:0] cofo_s3 [9];
	logic signed [CFW-1:0] cofo_s4 [9];
	logic signed [CFW-1:0] cofo_s5 [9];
	logic signed [CFW-1:0] dc_s2  [3];
	mi3_pkg::coef_t        mh_s2  [3];
	logic signed [CFW-1:0] c8_s2, c8_s3, c8_s4;
	logic signed [PLW-1:0] plo_s3 [3];
	logic signed [PW-1:0]  phi_s3 [3];
	logic signed [TW-1:0]  t_s4   [3];
	logic signed [DTW-1:0] det_s5;
	logic [DTW-1:0]        dmag_s6;
	logic                  dz_s6;
	logic [NMW-1:0]        num_s6 [9];
	logic                  neg_s6 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			tail_v_q <= '0;
		end else if (adv) begin
			v_s1     <= mat_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			tail_v_q <= {tail_v_q[LL-2:0], v_s6};
		end
	end

	logic signed [CFW-1:0] craw [9];
	logic signed [CFW-1:0] cadj [9];
	logic signed [CFW-1:0] cmag [9];

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			craw[i] = CFW'(pa_s1[i]) - CFW'(pb_s1[i]);
		end
		// 2x2 mode: swap the diagonal, negate the off-diagonal, zero the rest
		for (int i = 0; i < 9; i++) begin
			cadj[i] = mode_s1 ? craw[i] : '0;
		end
		if (!mode_s1) begin
			cadj[0] = CFW'(m_s1[4]);
			cadj[1] = -CFW'(m_s1[1]);
			cadj[3] = -CFW'(m_s1[3]);
			cadj[4] = CFW'(m_s1[0]);
		end
		for (int i = 0; i < 9; i++) begin
			cmag[i] = cofo_s5[i][CFW-1] ? -cofo_s5[i] : cofo_s5[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: entry products
			mode_s1 <= mat.mode_3x3;
			for (int i = 0; i < 9; i++) begin
				m_s1[i]  <= m_in[i];
				pa_s1[i] <= PW'(m_in[IA[i]]) * PW'(m_in[IB[i]]);
				pb_s1[i] <= PW'(m_in[IC[i]]) * PW'(m_in[ID[i]]);
			end
			// s2: cofactors
			mode_s2 <= mode_s1;
			cofo_s2 <= cadj;
			dc_s2[0] <= craw[0];
			dc_s2[1] <= craw[3];
			dc_s2[2] <= craw[6];
			c8_s2    <= craw[8];
			for (int k = 0; k < 3; k++) begin
				mh_s2[k] <= m_s1[k];
			end
			// s3: first-row entries times cofactor halves
			mode_s3 <= mode_s2;
			cofo_s3 <= cofo_s2;
			c8_s3   <= c8_s2;
			for (int k = 0; k < 3; k++) begin
				plo_s3[k] <= PLW'(mh_s2[k]) * $signed({1'b0, dc_s2[k][W:0]});
				phi_s3[k] <= PW'(mh_s2[k]) * PW'($signed(dc_s2[k][CFW-1:W+1]));
			end
			// s4: recombine halves into determinant terms
			mode_s4 <= mode_s3;
			cofo_s4 <= cofo_s3;
			c8_s4   <= c8_s3;
			for (int k = 0; k < 3; k++) begin
				t_s4[k] <= (TW'(phi_s3[k]) <<< (W + 1)) + TW'(plo_s3[k]);
			end
			// s5: determinant
			cofo_s5 <= cofo_s4;
			det_s5  <= mode_s4 ? (DTW'(t_s4[0]) + DTW'(t_s4[1]) + DTW'(t_s4[2]))
				: DTW'(c8_s4);
			// s6: magnitudes and signs for the divider lanes
			dmag_s6 <= det_s5[DTW-1] ? unsigned'(-det_s5) : unsigned'(det_s5);
			dz_s6   <= (det_s5 == '0);
			for (int i = 0; i < 9; i++) begin
				num_s6[i] <= NMW'(unsigned'(cmag[i])) << (2 * FRAC_BITS);
				neg_s6[i] <= cofo_s5[i][CFW-1] ^ det_s5[DTW-1];
			end
			tail_z_q <= {tail_z_q[LL-2:0], dz_s6};
		end
	end

	mi3_pkg::coef_t res [9];
	logic [8:0]     sat;

	genvar g;
	for (g = 0; g < 9; g++) begin : g_lane
		mi3_div_lane #(
			.NUM_W(NMW),
			.DEN_W(DTW)
		) u_lane (
			.clk (clk),
			.en  (adv),
			.num (num_s6[g]),
			.den (dmag_s6),
			.neg (neg_s6[g]),
			.res (res[g]),
			.sat (sat[g])
		);
	end

	// singular: force every entry to zero and drop the saturation flag
	logic dz_last;
	assign dz_last = tail_z_q[LL-1];

	always_comb begin
		pipe_word.inv_r0c0  = dz_last ? '0 : res[0];
		pipe_word.inv_r0c1  = dz_last ? '0 : res[1];
		pipe_word.inv_r0c2  = dz_last ? '0 : res[2];
		pipe_word.inv_r1c0  = dz_last ? '0 : res[3];
		pipe_word.inv_r1c1  = dz_last ? '0 : res[4];
		pipe_word.inv_r1c2  = dz_last ? '0 : res[5];
		pipe_word.inv_r2c0  = dz_last ? '0 : res[6];
		pipe_word.inv_r2c1  = dz_last ? '0 : res[7];
		pipe_word.inv_r2c2  = dz_last ? '0 : res[8];
		pipe_word.singular  = dz_last;
		pipe_word.saturated = !dz_last && (|sat);
	end

	// skid: hold a stalled word so that the pipeline may advance once more
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (!skid_v_q) begin
			skid_v_q <= tail_v_q[LL-1] && inv_stall;
		end else begin
			skid_v_q <= inv_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) begin
			skid_q <= pipe_word;
		end
	end

	assign mat_stall = skid_v_q;
	assign inv_valid = skid_v_q || tail_v_q[LL-1];
	assign inv       = skid_v_q ? skid_q : pipe_word;

endmodule

`default_nettype wire

>>> src/mi3_div_lane.sv
// One divider lane of the matrix inverse: pipelined restoring division of an
// unsigned numerator by an unsigned determinant, one quotient bit per stage,
// then round half away from zero, sign and saturate. Uses mi3_pkg.
`default_nettype none

module mi3_div_lane #(
	parameter int NUM_W = 96,
	parameter int DEN_W = 100
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic [NUM_W-1:0]     num,
	input  wire logic [DEN_W-1:0]     den,
	input  wire logic                 neg,
	output mi3_pkg::coef_t            res,
	output logic                      sat
);

	localparam int W   = mi3_pkg::COEF_W;
	localparam int QW  = W + 1;
	localparam int DSH = DEN_W + W + 1;
	localparam int XW  = ((NUM_W > DSH) ? NUM_W : DSH) + 1;
	localparam int VW  = W + 2;

	logic [XW-1:0]    rem_s [QW];
	logic [QW-1:0]    quo_s [QW];
	logic [DEN_W-1:0] den_s [QW];
	logic             neg_s [QW];
	logic             big_s [QW];

	genvar k;
	for (k = 0; k < QW; k++) begin : g_stage
		localparam int SH = W - k;
		logic [XW-1:0]    r_in;
		logic [XW-1:0]    d_sh;
		logic [QW-1:0]    q_in;
		logic [DEN_W-1:0] d_in;
		logic             n_in;
		logic             b_in;
		logic             ge;

		if (k == 0) begin : g_first
			// quotient too large for W+1 bits: clamp later
			assign r_in = XW'(num);
			assign q_in = '0;
			assign d_in = den;
			assign n_in = neg;
			assign b_in = (XW'(num) >= (XW'(den) << (W + 1)));
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign q_in = quo_s[k-1];
			assign d_in = den_s[k-1];
			assign n_in = neg_s[k-1];
			assign b_in = big_s[k-1];
		end

		assign d_sh = XW'(d_in) << SH;
		assign ge   = (r_in >= d_sh);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? (r_in - d_sh) : r_in;
				quo_s[k] <= q_in | (QW'(ge) << SH);
				den_s[k] <= d_in;
				neg_s[k] <= n_in;
				big_s[k] <= b_in;
			end
		end
	end

	logic [XW:0]   twice;
	logic          rup;
	logic [VW-1:0] mag;
	logic [VW-1:0] lim;
	logic          ovf;
	logic [VW-1:0] clamped;
	logic [VW-1:0] signed_v;

	always_comb begin
		twice    = {rem_s[QW-1], 1'b0};
		rup      = (twice >= (XW + 1)'(den_s[QW-1]));
		mag      = VW'(quo_s[QW-1]) + VW'(rup);
		lim      = VW'(1) << (W - 1);
		ovf      = big_s[QW-1] | (neg_s[QW-1] ? (mag > lim) : (mag > (lim - VW'(1))));
		clamped  = ovf ? (neg_s[QW-1] ? lim : (lim - VW'(1))) : mag;
		signed_v = neg_s[QW-1] ? (VW'(0) - clamped) : clamped;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res <= signed_v[W-1:0];
			sat <= ovf;
		end
	end

endmodule

`default_nettype wire

>>> src/mi3_chk.sv
// Port checker of the 3x3 matrix inverse, bound to the top level.
// Uses mi3_pkg and the macros of assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mi3_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               mat_valid,
	input wire logic               mat_stall,
	input wire mi3_pkg::mat_word_t mat,
	input wire logic               inv_valid,
	input wire logic               inv_stall,
	input wire mi3_pkg::inv_word_t inv
);

	wire all_zero = (inv.inv_r0c0 == '0) && (inv.inv_r0c1 == '0) && (inv.inv_r0c2 == '0)
		&& (inv.inv_r1c0 == '0) && (inv.inv_r1c1 == '0) && (inv.inv_r1c2 == '0)
		&& (inv.inv_r2c0 == '0) && (inv.inv_r2c1 == '0) && (inv.inv_r2c2 == '0);
	wire unused_ok = mat_valid || (mat != mat);

	`MI3_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !inv_valid && !mat_stall, "word out in reset")
	`MI3_ASSERT(a_out_hold, inv_valid && inv_stall |=> inv_valid && $stable(inv), "stalled word moved")
	`MI3_ASSERT(a_stall_cause, mat_stall && unused_ok |-> $past(inv_valid && inv_stall), "stall without cause")
	`MI3_ASSERT(a_singular_zero, inv_valid && inv.singular |-> all_zero && !inv.saturated, "singular word not zero")

endmodule

bind matrix_inverse_3x3 mi3_chk u_chk (.*);

`default_nettype wire
